/* design/tccw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console character writer package
// Screen geometry, derived widths, character and function codes, and the
// mapping from a screen position to a cell address in the screen store.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Screen geometry.
  localparam int ROW_COUNT  = 25;
  localparam int COL_COUNT  = 80;
  localparam int CELL_COUNT = ROW_COUNT * COL_COUNT;

  // Derived widths.
  localparam int ROW_W  = $clog2(ROW_COUNT);
  localparam int COL_W  = $clog2(COL_COUNT);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CELL_W = 16;

  // Attribute after reset.
  localparam logic [7:0] ATTR_RESET = 8'h0f;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_RETURN  = 8'h0d;

  // Function codes of an input word.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // The store is a ring of rows: base is the physical row that holds the
  // top screen row. Both operands are below ROW_COUNT, so one subtract
  // brings the sum back into range.
  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic [ROW_W-1:0] base,
    input logic [ROW_W-1:0] row,
    input logic [COL_W-1:0] col
  );
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] phys;
    sum = {1'b0, base} + {1'b0, row};
    if (sum >= (ROW_W+1)'(ROW_COUNT)) begin
      sum = sum - (ROW_W+1)'(ROW_COUNT);
    end
    phys = sum[ROW_W-1:0];
    return ADDR_W'(phys) * ADDR_W'(COL_COUNT) + ADDR_W'(col);
  endfunction

endpackage

/* design/tccw_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/text_console_char_writer_core.sv */
// ----------------------------------------------------------------------------
// Text console character writer
// Keeps a cursor and a screen of attribute/character cells, writes
// characters at the cursor, scrolls at the bottom row and reads cells back.
// ----------------------------------------------------------------------------
// Usage:
// Each input word either writes a character (func 0) or reads one cell
// (func 1). Every input word gives exactly one result word carrying the
// cell value, the cursor after the word and the counted flag.
// A write, newline or carriage return is handled in the cycle it is taken
// and its result is registered at the same edge. A read waits in the read
// state on the registered read port of the screen store. A newline or
// line wrap on the bottom row also starts a scroll: the screen is a ring
// of rows, so only the new bottom row is refilled, one cell a cycle, while
// input stays stalled; its result is delivered meanwhile. After reset the
// screen store is cleared one cell a cycle, with input stalled; attribute
// writes are taken at any time. A result waits in the output register
// while out_stall is high; the next input word is taken in the cycle in
// which that result leaves.
// ----------------------------------------------------------------------------
module text_console_char_writer_core
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port.
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_cell_value,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic        out_counted
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_READ   = 4'b0100,
    S_SCROLL = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [7:0]         attr_r;
  logic [7:0]         fill_r, fill_nxt;
  logic [COL_W-1:0]   cur_x_r, cur_x_nxt;
  logic [ROW_W-1:0]   cur_y_r, cur_y_nxt;
  logic [ROW_W-1:0]   base_r, base_nxt;
  logic [ADDR_W-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic [COL_W-1:0]   sweep_col_r, sweep_col_nxt;
  logic               in_range_r, in_range_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_value_r, out_value_nxt;
  logic [6:0]         out_col_r, out_col_nxt;
  logic [4:0]         out_row_r, out_row_nxt;
  logic               out_counted_r, out_counted_nxt;

  logic               accept;
  logic               rd_in_range;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CELL_W-1:0]  wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CELL_W-1:0]  rd_data;

  // Screen store, organised as a ring of rows.
  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Input is taken only when idle and the output register is free.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // A read outside the screen returns zero.
  assign rd_in_range = (32'(in_read_row) < ROW_COUNT) && (32'(in_read_col) < COL_COUNT);
  assign rd_addr     = cell_addr(base_r, ROW_W'(in_read_row), COL_W'(in_read_col));

  // Sequencer: clearing pass, word handling, read completion and row refill.
  always_comb begin
    logic do_line;
    logic do_word;
    do_line         = 1'b0;
    do_word         = 1'b0;
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    base_nxt        = base_r;
    sweep_addr_nxt  = sweep_addr_r;
    sweep_col_nxt   = sweep_col_r;
    in_range_nxt    = in_range_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_value_nxt   = out_value_r;
    out_col_nxt     = out_col_r;
    out_row_nxt     = out_row_r;
    out_counted_nxt = out_counted_r;
    wr_en           = 1'b0;
    wr_addr         = sweep_addr_r;
    wr_data         = '0;

    unique case (state_r)
      S_CLEAR: begin
        wr_en          = 1'b1;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_addr_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_READ) begin
            in_range_nxt = rd_in_range;
            state_nxt    = S_READ;
          end else if (in_char_code == CH_NEWLINE) begin
            do_line = 1'b1;
            do_word = 1'b1;
          end else if (in_char_code == CH_RETURN) begin
            do_word = 1'b1;
          end else begin
            // Printable cell at the cursor, then advance with line wrap.
            wr_en   = 1'b1;
            wr_addr = cell_addr(base_r, cur_y_r, cur_x_r);
            wr_data = {attr_r, in_char_code};
            do_word = 1'b1;
            if (cur_x_r == COL_W'(COL_COUNT - 1)) begin
              do_line = 1'b1;
            end else begin
              cur_x_nxt = cur_x_r + 1'b1;
            end
          end

          // Next line: on the bottom row the ring turns by one row and the
          // old top row is refilled as the new bottom row.
          if (do_line) begin
            cur_x_nxt = '0;
            if (cur_y_r == ROW_W'(ROW_COUNT - 1)) begin
              base_nxt       = (base_r == ROW_W'(ROW_COUNT - 1)) ? '0 : base_r + 1'b1;
              sweep_addr_nxt = ADDR_W'(base_r) * ADDR_W'(COL_COUNT);
              sweep_col_nxt  = '0;
              fill_nxt       = attr_r;
              state_nxt      = S_SCROLL;
            end else begin
              cur_y_nxt = cur_y_r + 1'b1;
            end
          end

          // Result word of a write, newline or carriage return.
          if (do_word) begin
            out_valid_nxt   = 1'b1;
            out_value_nxt   = '0;
            out_col_nxt     = 7'(cur_x_nxt);
            out_row_nxt     = 5'(cur_y_nxt);
            out_counted_nxt = (in_char_code != CH_RETURN);
          end
        end
      end

      S_READ: begin
        out_valid_nxt   = 1'b1;
        out_value_nxt   = in_range_r ? rd_data : '0;
        out_col_nxt     = 7'(cur_x_r);
        out_row_nxt     = 5'(cur_y_r);
        out_counted_nxt = 1'b0;
        state_nxt       = S_IDLE;
      end

      S_SCROLL: begin
        wr_en          = 1'b1;
        wr_data        = {fill_r, 8'h00};
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        sweep_col_nxt  = sweep_col_r + 1'b1;
        if (sweep_col_r == COL_W'(COL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      attr_r       <= ATTR_RESET;
      cur_x_r      <= '0;
      cur_y_r      <= ROW_W'(ROW_COUNT - 1);
      base_r       <= '0;
      sweep_addr_r <= '0;
      sweep_col_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      base_r       <= base_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_col_r  <= sweep_col_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fill_r        <= fill_nxt;
    in_range_r    <= in_range_nxt;
    out_value_r   <= out_value_nxt;
    out_col_r     <= out_col_nxt;
    out_row_r     <= out_row_nxt;
    out_counted_r <= out_counted_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_counted    = out_counted_r;

  // A read always completes into the output register in the cycle after the read state.
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> out_valid_r)
    else $error("read did not produce a result word");

  // The cursor never leaves the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cur_x_r) < COL_COUNT) && (32'(cur_y_r) < ROW_COUNT))
    else $error("cursor outside the screen");

  // The ring base always names a physical row.
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(base_r) < ROW_COUNT)
    else $error("ring base outside the store");

  // A refill lasts exactly one row and then returns to idle.
  a_scroll_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL && sweep_col_r == COL_W'(COL_COUNT - 1)) |=> (state_r == S_IDLE))
    else $error("row refill did not end after one row");

endmodule
